>>> rtl/ltp_pkg.sv
// Shared types and constants for the auto-off percent timer.
// No dependencies; used by every file of the block.
package ltp_pkg;

    localparam int MS_W   = 33;
    localparam int RATE_W = 16;
    localparam int PCT_W  = 7;
    localparam int DSR_W  = 26;
    localparam int PROD_W = PCT_W + RATE_W;
    localparam int CNT_W  = 6;

    localparam logic [PCT_W-1:0] C_FULL_PCT  = 7'd100;
    localparam logic [PCT_W-1:0] C_ALWAYS_TH = 7'd95;
    localparam logic [PCT_W-1:0] C_Q_SAT     = 7'd99;
    localparam logic [9:0]       C_MS_PER_S  = 10'd1000;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SET_OUT = 2'd1,
        OP_SET_PCT = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_RATE   = 2'd0,
        CFG_START  = 2'd1,
        CFG_ALWAYS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quot;
    } t_div_res;

endpackage

>>> rtl/ltp_if.sv
// Channel interfaces: input items, result items and register writes.
// Depends on ltp_pkg.
interface ltp_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic [ltp_pkg::PCT_W-1:0] value;
    modport source (output valid, operation, value, input ready);
    modport sink (input valid, operation, value, output ready);
endinterface

interface ltp_out_if;
    logic                      valid;
    logic                      ready;
    logic [ltp_pkg::PCT_W-1:0] pct_left;
    logic                      light_on;
    logic                      notify;
    modport source (output valid, pct_left, light_on, notify, input ready);
    modport sink (input valid, pct_left, light_on, notify, output ready);
endinterface

interface ltp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 index;
    logic [ltp_pkg::RATE_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/light_auto_off_percent_timer_core.sv
// Top level of the auto-off light timer with percent report.
// Depends on ltp_pkg, ltp_if and ltp_div.
//
//  channel   modport  payload                                 handshake
//  i_in      sink     operation[1:0], value[6:0]              valid/ready
//  o_res     source   pct_left[6:0], light_on, notify         valid/ready
//  i_cfg     sink     index[1:0], data[15:0]                  valid/ready, ready tied high
//
// A new item is taken only once the last one is through. With the timer running
// an item passes the divider, floor(ms / (1000 * rate)); an arming item first
// passes S_MUL and S_SCALE. Items with an idle timer or rate zero skip the divider.
// Reset is synchronous and clears the timer, light and report history.
// The result waits in an output register; the next item is taken meanwhile and
// holds in its last state until the register is free.
module light_auto_off_percent_timer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ltp_in_if.sink     i_in,
    ltp_out_if.source  o_res,
    ltp_cfg_if.sink    i_cfg
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_SCALE = 6'b000100,
        S_START = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                          r_state;
    ltp_pkg::t_op                    r_op;
    logic [ltp_pkg::MS_W-1:0]        r_ms;
    logic                            r_light;
    logic [ltp_pkg::PCT_W-1:0]       r_arm_pct;
    logic [ltp_pkg::PROD_W-1:0]      r_prod;
    logic [ltp_pkg::PCT_W-1:0]       r_pct;
    logic [ltp_pkg::PCT_W-1:0]       r_rep_pct;
    logic                            r_rep_none;
    logic                            r_rep_light;
    logic [ltp_pkg::RATE_W-1:0]      r_rate;
    logic [ltp_pkg::PCT_W-1:0]       r_start;
    logic                            r_always;
    logic                            r_ovalid;
    logic [ltp_pkg::PCT_W-1:0]       r_opct;
    logic                            r_olight;
    logic                            r_onotify;

    ltp_pkg::t_op                    w_op;
    logic [ltp_pkg::PCT_W-1:0]       w_sp;
    logic [ltp_pkg::PCT_W-1:0]       w_vp;
    logic [ltp_pkg::PCT_W-1:0]       w_pick;
    logic                            w_arm_ok;
    logic                            w_want;
    logic                            w_in_xfer;
    logic                            w_div_start;
    logic [ltp_pkg::DSR_W-1:0]       w_divisor;
    logic                            w_notify;
    logic                            w_out_free;
    ltp_pkg::t_div_res               w_div;

    always_comb begin
        w_op = ltp_pkg::t_op'(i_in.operation);
        if (r_start == '0) begin
            w_sp = 7'd1;
        end else if (r_start > ltp_pkg::C_FULL_PCT) begin
            w_sp = ltp_pkg::C_FULL_PCT;
        end else begin
            w_sp = r_start;
        end
        w_vp     = (i_in.value > ltp_pkg::C_FULL_PCT) ? ltp_pkg::C_FULL_PCT : i_in.value;
        w_pick   = (w_op == ltp_pkg::OP_SET_OUT) ? w_sp : w_vp;
        w_arm_ok = (w_pick != '0) && (r_rate != '0) &&
                   ((w_pick <= ltp_pkg::C_ALWAYS_TH) || !r_always);
        w_want   = (i_in.value != '0);
    end

    always_comb begin
        case (r_op)
            ltp_pkg::OP_TICK, ltp_pkg::OP_SET_OUT: begin
                w_notify = r_rep_none || (r_pct != r_rep_pct) || (r_light != r_rep_light);
            end
            ltp_pkg::OP_SET_PCT: begin
                w_notify = 1'b1;
            end
            default: begin
                w_notify = 1'b0;
            end
        endcase
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign w_out_free  = !r_ovalid || o_res.ready;
    assign w_div_start = (r_state == S_START) && (r_ms != '0) && (r_rate != '0);
    assign w_divisor   = ltp_pkg::DSR_W'(r_rate) * ltp_pkg::DSR_W'(ltp_pkg::C_MS_PER_S);

    ltp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_ms),
        .i_divisor  (w_divisor),
        .o_res      (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= '0;
            r_start  <= ltp_pkg::C_FULL_PCT;
            r_always <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ltp_pkg::CFG_RATE:   r_rate   <= i_cfg.data;
                ltp_pkg::CFG_START:  r_start  <= i_cfg.data[ltp_pkg::PCT_W-1:0];
                ltp_pkg::CFG_ALWAYS: r_always <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= ltp_pkg::OP_READ;
            r_ms        <= '0;
            r_light     <= 1'b0;
            r_rep_pct   <= '0;
            r_rep_none  <= 1'b1;
            r_rep_light <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_op      <= w_op;
                        r_arm_pct <= w_pick;
                        r_state   <= S_START;
                        case (w_op)
                            ltp_pkg::OP_TICK: begin
                                if (r_ms != '0) begin
                                    r_ms <= r_ms - 1'b1;
                                    if (r_ms == ltp_pkg::MS_W'(1)) begin
                                        r_light <= 1'b0;
                                    end
                                end
                            end
                            ltp_pkg::OP_SET_OUT: begin
                                r_light <= w_want;
                                if (w_want && !r_light && w_arm_ok) begin
                                    r_state <= S_MUL;
                                end else begin
                                    r_ms <= '0;
                                end
                            end
                            ltp_pkg::OP_SET_PCT: begin
                                if (w_arm_ok) begin
                                    r_state <= S_MUL;
                                end else begin
                                    r_ms <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= ltp_pkg::PROD_W'(r_arm_pct) * ltp_pkg::PROD_W'(r_rate);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_ms    <= ltp_pkg::MS_W'(r_prod) * ltp_pkg::MS_W'(ltp_pkg::C_MS_PER_S);
                    r_state <= S_START;
                end
                S_START: begin
                    if (r_ms == '0) begin
                        r_pct   <= (r_light && r_always) ? ltp_pkg::C_FULL_PCT : '0;
                        r_state <= S_DONE;
                    end else if (r_rate == '0) begin
                        r_pct   <= ltp_pkg::C_FULL_PCT;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_pct   <= w_div.quot + 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_opct    <= r_pct;
                        r_olight  <= r_light;
                        r_onotify <= w_notify;
                        if (r_op != ltp_pkg::OP_READ) begin
                            r_rep_pct   <= r_pct;
                            r_rep_light <= r_light;
                            r_rep_none  <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid    = r_ovalid;
    assign o_res.pct_left = r_opct;
    assign o_res.light_on = r_olight;
    assign o_res.notify   = r_onotify;

endmodule

>>> rtl/ltp_div.sv
// Iterative restoring divider, one quotient bit per cycle, quotient saturated.
// Depends on ltp_pkg.
module ltp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ltp_pkg::MS_W-1:0]   i_dividend,
    input  logic [ltp_pkg::DSR_W-1:0]  i_divisor,
    output ltp_pkg::t_div_res          o_res
);

    logic [ltp_pkg::DSR_W-1:0]  r_rem;
    logic [ltp_pkg::DSR_W-1:0]  r_dsr;
    logic [ltp_pkg::MS_W-1:0]   r_dvd;
    logic [ltp_pkg::CNT_W-1:0]  r_cnt;
    logic [ltp_pkg::PCT_W-1:0]  r_q;
    logic                       r_sat;
    logic                       r_busy;
    logic                       r_done;

    logic [ltp_pkg::DSR_W:0]    w_trial;
    logic                       w_bit;
    logic [ltp_pkg::DSR_W-1:0]  n_rem;
    logic [ltp_pkg::PCT_W:0]    w_q2;
    logic                       n_sat;

    always_comb begin
        w_trial = {r_rem, r_dvd[ltp_pkg::MS_W-1]};
        w_bit   = (w_trial >= {1'b0, r_dsr});
        n_rem   = w_bit ? ltp_pkg::DSR_W'(w_trial - {1'b0, r_dsr})
                        : w_trial[ltp_pkg::DSR_W-1:0];
        w_q2    = {r_q, w_bit};
        n_sat   = r_sat || (w_q2 >= {1'b0, ltp_pkg::C_Q_SAT});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_dsr  <= i_divisor;
                r_dvd  <= i_dividend;
                r_cnt  <= '0;
                r_q    <= '0;
                r_sat  <= 1'b0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[ltp_pkg::MS_W-2:0], 1'b0};
                r_sat <= n_sat;
                r_q   <= n_sat ? ltp_pkg::C_Q_SAT : w_q2[ltp_pkg::PCT_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ltp_pkg::CNT_W'(ltp_pkg::MS_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_q;

endmodule
